>>> hw/rtl/gamepad_menu_key_autorepeat_macros.svh
// assertion macros for the gamepad menu key autorepeat block
`ifndef GAMEPAD_MENU_KEY_AUTOREPEAT_MACROS_SVH
`define GAMEPAD_MENU_KEY_AUTOREPEAT_MACROS_SVH

// same-cycle implication on clk_i, off while in reset
`define GMKA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off while in reset
`define GMKA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/gmka_pkg.sv
// types, constants and tables shared by the gamepad menu key autorepeat block
package gmka_pkg;

  localparam int unsigned NumDirs = 4;
  localparam int unsigned NumBtns = 8;

  localparam logic [15:0] ResetDelay     = 16'd350;
  localparam logic [15:0] ResetRate      = 16'd100;
  localparam logic [14:0] ResetThreshold = 15'(32767 / 2);
  localparam logic [3:0]  ResetBtnCount  = 4'd8;
  localparam logic [7:0]  CountMax       = 8'd255;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    CfgPadPresent    = 3'd0,
    CfgRepeatDelay   = 3'd1,
    CfgRepeatRate    = 3'd2,
    CfgAxisThreshold = 3'd3,
    CfgButtonCount   = 3'd4,
    CfgStickPresent  = 3'd5
  } cfg_idx_e;

  localparam logic FuncButton = 1'b0;
  localparam logic FuncPoll   = 1'b1;

  localparam logic [3:0] KeyNone  = 4'd0;
  localparam logic [3:0] KeyUp    = 4'd1;
  localparam logic [3:0] KeyDown  = 4'd2;
  localparam logic [3:0] KeyLeft  = 4'd3;
  localparam logic [3:0] KeyRight = 4'd4;
  localparam logic [3:0] KeyEnter = 4'd5;
  localparam logic [3:0] KeyEsc   = 4'd6;
  localparam logic [3:0] KeySpace = 4'd7;
  localparam logic [3:0] KeyHelp  = 4'd8;
  localparam logic [3:0] KeyPgUp  = 4'd9;
  localparam logic [3:0] KeyPgDn  = 4'd10;

  // button scan order and the key each entry gives
  localparam logic [2:0] BtnOrder [NumBtns] = '{3'd0, 3'd7, 3'd1, 3'd6, 3'd2, 3'd3, 3'd4, 3'd5};
  localparam logic [3:0] BtnKey   [NumBtns] = '{KeyEnter, KeyEnter, KeyEsc, KeyEsc,
                                                KeySpace, KeyHelp, KeyPgUp, KeyPgDn};

  // per-direction command from the poll stage
  typedef struct packed {
    logic        step;
    logic        down;
    logic [31:0] now;
  } dir_cmd_t;

endpackage

>>> hw/rtl/gmka_dir.sv
// autorepeat timer of one menu direction
module gmka_dir
  import gmka_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dir_cmd_t    cmd_i,
  input  logic [15:0] delay_i,
  input  logic [15:0] rate_i,
  output logic        fire_o
);

  logic        held_q, held_d;
  logic [31:0] deadline_q, deadline_d;
  logic [31:0] step_add;

  always_comb begin
    fire_o     = cmd_i.down && (!held_q || (cmd_i.now >= deadline_q));
    step_add   = held_q ? {16'b0, rate_i} : {16'b0, delay_i};
    held_d     = held_q;
    deadline_d = deadline_q;
    if (cmd_i.step) begin
      if (!cmd_i.down) begin
        held_d     = 1'b0;
        deadline_d = '0;
      end else if (fire_o) begin
        held_d     = 1'b1;
        deadline_d = cmd_i.now + step_add;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= 1'b0;
      deadline_q <= '0;
    end else begin
      held_q     <= held_d;
      deadline_q <= deadline_d;
    end
  end

endmodule

>>> hw/rtl/gamepad_menu_key_autorepeat.sv
// gamepad menu key generator with direction autorepeat, top level
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_ready_o   func, button_index, button_pressed,
//                                               now_ms, hat_levels, stick_x, stick_y
//   out      source     out_valid_o/out_ready_i key_code (polls only)
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index, cfg_data (always ready)
//
// one item per cycle unless a poll waits behind a full, stalled key register;
// a poll's key passes the input register and then the key register
// the work sits between the input register and the key register
// a button event retires from the input register even while a key waits
// a poll waits in the input register only while the key register is full and stalled
// reset clears counters, timers and configuration to their defaults
module gamepad_menu_key_autorepeat
  import gmka_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [2:0]  button_index_i,
  input  logic        button_pressed_i,
  input  logic [31:0] now_ms_i,
  input  logic [3:0]  hat_levels_i,
  input  logic signed [15:0] stick_x_i,
  input  logic signed [15:0] stick_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  key_code_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // configuration
  logic        pad_present_q;
  logic [15:0] repeat_delay_q;
  logic [15:0] repeat_rate_q;
  logic [14:0] axis_threshold_q;
  logic [3:0]  button_count_q;
  logic        stick_present_q;

  // input register
  logic        in_vld_q;
  logic        func_q;
  logic [2:0]  btn_idx_q;
  logic        btn_press_q;
  logic [31:0] now_q;
  logic [3:0]  hat_q;
  logic signed [15:0] stick_x_q, stick_y_q;

  // result register
  logic        out_vld_q;
  logic [3:0]  key_q, key_d;

  logic [7:0]  press_count_q [NumBtns];
  logic [7:0]  press_count_d [NumBtns];

  logic        advance;
  logic        poll_step;
  logic [NumDirs-1:0] dir_down;
  logic [NumDirs-1:0] dir_fire;
  dir_cmd_t    dir_cmd [NumDirs];
  logic signed [16:0] thr_pos, thr_neg, x_ext, y_ext;
  logic        btn_key_found;

  assign cfg_ready_o = 1'b1;
  assign advance     = in_vld_q && ((func_q == FuncButton) || !out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;
  assign poll_step   = advance && (func_q == FuncPoll) && pad_present_q;
  assign out_valid_o = out_vld_q;
  assign key_code_o  = key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_present_q    <= 1'b1;
      repeat_delay_q   <= ResetDelay;
      repeat_rate_q    <= ResetRate;
      axis_threshold_q <= ResetThreshold;
      button_count_q   <= ResetBtnCount;
      stick_present_q  <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgPadPresent:    pad_present_q    <= cfg_data_i[0];
        CfgRepeatDelay:   repeat_delay_q   <= cfg_data_i;
        CfgRepeatRate:    repeat_rate_q    <= cfg_data_i;
        CfgAxisThreshold: axis_threshold_q <= cfg_data_i[14:0];
        CfgButtonCount:   button_count_q   <= cfg_data_i[3:0];
        CfgStickPresent:  stick_present_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q      <= func_i;
      btn_idx_q   <= button_index_i;
      btn_press_q <= button_pressed_i;
      now_q       <= now_ms_i;
      hat_q       <= hat_levels_i;
      stick_x_q   <= stick_x_i;
      stick_y_q   <= stick_y_i;
    end
  end

  // direction levels: hat bits ORed with the stick against the threshold when a stick is present
  always_comb begin
    thr_pos  = $signed({2'b00, axis_threshold_q});
    thr_neg  = -thr_pos;
    x_ext    = 17'(stick_x_q);
    y_ext    = 17'(stick_y_q);
    dir_down = {hat_q[1], hat_q[3], hat_q[2], hat_q[0]};
    if (stick_present_q) begin
      if (y_ext < thr_neg) begin
        dir_down[0] = 1'b1;
      end else if (y_ext > thr_pos) begin
        dir_down[1] = 1'b1;
      end
      if (x_ext < thr_neg) begin
        dir_down[2] = 1'b1;
      end else if (x_ext > thr_pos) begin
        dir_down[3] = 1'b1;
      end
    end
  end

  for (genvar d = 0; d < NumDirs; d++) begin : g_dir
    assign dir_cmd[d] = '{step: poll_step, down: dir_down[d], now: now_q};

    gmka_dir u_dir (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (dir_cmd[d]),
      .delay_i (repeat_delay_q),
      .rate_i  (repeat_rate_q),
      .fire_o  (dir_fire[d])
    );
  end

  // key selection and press counter update
  always_comb begin
    key_d         = KeyNone;
    btn_key_found = 1'b0;
    for (int b = 0; b < NumBtns; b++) begin
      press_count_d[b] = press_count_q[b];
    end

    if (advance && (func_q == FuncButton)) begin
      if (btn_press_q && (press_count_q[btn_idx_q] != CountMax)) begin
        press_count_d[btn_idx_q] = press_count_q[btn_idx_q] + 8'd1;
      end
    end

    if (pad_present_q) begin
      if (dir_fire[0]) begin
        key_d = KeyUp;
      end else if (dir_fire[1]) begin
        key_d = KeyDown;
      end else if (dir_fire[2]) begin
        key_d = KeyLeft;
      end else if (dir_fire[3]) begin
        key_d = KeyRight;
      end else begin
        // scan present buttons in table order, clearing each on a poll step
        for (int i = 0; i < NumBtns; i++) begin
          if ({1'b0, BtnOrder[i]} < button_count_q) begin
            if (!btn_key_found && (press_count_q[BtnOrder[i]] != 8'd0)) begin
              key_d         = BtnKey[i];
              btn_key_found = 1'b1;
            end
            if (poll_step) begin
              press_count_d[BtnOrder[i]] = 8'd0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NumBtns; b++) begin
        press_count_q[b] <= 8'd0;
      end
    end else begin
      for (int b = 0; b < NumBtns; b++) begin
        press_count_q[b] <= press_count_d[b];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && (func_q == FuncPoll)) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && (func_q == FuncPoll)) begin
      key_q <= key_d;
    end
  end

endmodule

>>> hw/rtl/gmka_chk.sv
// port-level checker for the gamepad menu key autorepeat block
`include "gamepad_menu_key_autorepeat_macros.svh"

module gmka_chk
  import gmka_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        func_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [3:0]  key_code_o
);

  // a held key stays put until its transfer
  `GMKA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(key_code_o), "key changed while stalled")

  `GMKA_ASSERT_NOW(a_key_range, out_valid_o, key_code_o <= KeyPgDn,
    "key code out of range")

  // input side only stalls behind a full, stalled key register
  `GMKA_ASSERT_NOW(a_stall_cause, !in_ready_o, out_valid_o && !out_ready_i,
    "input stalled without output backpressure")

  // a fresh key comes from a poll that passed the input register and then the key register
  `GMKA_ASSERT_NOW(a_key_source, $rose(out_valid_o),
    $past(in_valid_i && in_ready_o && (func_i == FuncPoll), 2),
    "key without a poll")

endmodule

bind gamepad_menu_key_autorepeat gmka_chk u_gmka_chk (.*);
